FILE: sv/ssd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and font functions for the seven-segment driver.
// No dependencies; the interfaces and the top level import this package.
package ssd_pkg;

    // Payload widths of the item and result channels.
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 8;
    localparam int CODE_W   = 8;
    localparam int SEG_W    = 8;
    localparam int ACTIVE_W = 2;

    // Register map and register width.
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int MASK_W   = 4;
    localparam logic [MASK_W-1:0] MASK_RESET = 4'd4;

    // Item operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_POINT = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    // Register indexes.
    typedef enum logic [0:0] {
        REG_UD_MASK = 1'b0
    } t_reg;

    // Character codes with special handling.
    localparam logic [CODE_W-1:0] CODE_DEGREE = 8'd248;
    localparam logic [CODE_W-1:0] CODE_MINUS  = 8'd45;
    localparam logic [CODE_W-1:0] CODE_LOWER_A = 8'd97;
    localparam logic [CODE_W-1:0] CODE_LOWER_Z = 8'd122;
    localparam logic [CODE_W-1:0] CASE_OFFSET  = 8'd32;
    localparam logic [CODE_W-1:0] CODE_ZERO    = 8'd48;
    localparam logic [CODE_W-1:0] CODE_NINE    = 8'd57;
    localparam logic [CODE_W-1:0] CODE_UPPER_A = 8'd65;
    localparam logic [CODE_W-1:0] CODE_UPPER_Z = 8'd90;

    localparam logic [6:0] GLYPH_MINUS  = 7'h40;
    localparam logic [6:0] GLYPH_DEGREE = 7'h63;
    localparam logic [6:0] GLYPH_BLANK  = 7'h00;

    typedef logic [6:0] t_glyph;

    localparam t_glyph NUMERAL_FONT [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    localparam t_glyph LETTER_FONT [26] = '{
        7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h30, 7'h1E,
        7'h76, 7'h38, 7'h15, 7'h54, 7'h3F, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78,
        7'h3E, 7'h1C, 7'h2A, 7'h76, 7'h6E, 7'h1B
    };

    // Font lookup: lower case folds to upper case, unknown codes are blank.
    function automatic t_glyph glyph_of(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] folded;
        logic [CODE_W-1:0] offset;
        t_glyph            g;
        folded = code;
        if (code >= CODE_LOWER_A && code <= CODE_LOWER_Z) begin
            folded = code - CASE_OFFSET;
        end
        g = GLYPH_BLANK;
        if (folded >= CODE_ZERO && folded <= CODE_NINE) begin
            offset = folded - CODE_ZERO;
            g = NUMERAL_FONT[offset[3:0]];
        end else if (folded >= CODE_UPPER_A && folded <= CODE_UPPER_Z) begin
            offset = folded - CODE_UPPER_A;
            g = LETTER_FONT[offset[4:0]];
        end else if (folded == CODE_MINUS) begin
            g = GLYPH_MINUS;
        end else if (folded == CODE_DEGREE) begin
            g = GLYPH_DEGREE;
        end
        return g;
    endfunction

    // Half-turn of a glyph: swap A/D, B/E and C/F, keep G.
    function automatic t_glyph turn_over(input t_glyph g);
        return {g[6], g[2:0], g[5:3]};
    endfunction

endpackage

FILE: sv/ssd_in_if.sv
`timescale 1ns / 1ps
// Item channel of the seven-segment driver: valid/ready plus item payload.
// Depends on ssd_pkg for the field widths.
interface ssd_in_if
    import ssd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] digit_index;
    logic [CODE_W-1:0]  char_code;
    logic               dp_on;

    modport source (output valid, output op, output digit_index, output char_code,
                    output dp_on, input ready);
    modport sink   (input valid, input op, input digit_index, input char_code,
                    input dp_on, output ready);
endinterface

FILE: sv/ssd_out_if.sv
`timescale 1ns / 1ps
// Result channel of the seven-segment driver: valid/ready plus pattern and digit.
// Depends on ssd_pkg for the field widths.
interface ssd_out_if
    import ssd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SEG_W-1:0]    segment_bits;
    logic [ACTIVE_W-1:0] active_digit;

    modport source (output valid, output segment_bits, output active_digit,
                    input ready);
    modport sink   (input valid, input segment_bits, input active_digit,
                    output ready);
endinterface

FILE: sv/seven_segment_char_mux_driver.sv
`timescale 1ns / 1ps
// Top level of the multiplexed seven-segment driver: font, pattern store, scan.
// Depends on ssd_pkg, ssd_in_if and ssd_out_if.
//
//  Channel  | Direction | Handshake                    | Carries
//  ---------+-----------+------------------------------+-------------------------------
//  i_in     | in        | valid/ready                  | op, digit_index, char_code, dp_on
//  o_out    | out       | valid/ready                  | segment_bits, active_digit
//  APB      | in        | psel/penable/pwrite, pready=1 | upside_down_mask at address 0
//
// One item is accepted per cycle while input ready is high. Write and point items update the
// segment or decimal-point memory at the accepting edge; a tick reads both memories into the
// read stage, and its result then moves on into the output register.
// A synchronous reset clears the scan position, the memory valid bits and the pipeline valid flags.
// A full output register that is not drained stalls the read stage; input ready drops only then.

module seven_segment_char_mux_driver
    import ssd_pkg::*;
#(
    parameter int NUM_DIGITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ssd_in_if.sink               i_in,
    ssd_out_if.source            o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int IW   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int EXTW = (IW > ACTIVE_W) ? IW : ACTIVE_W;

    // Configuration register.
    logic [MASK_W-1:0] r_ud_mask;
    logic              w_cfg_wr;
    logic              w_cfg_sel;

    assign pready    = 1'b1;
    assign w_cfg_sel = (paddr[2] == REG_UD_MASK);
    assign w_cfg_wr  = psel && penable && pwrite && w_cfg_sel;
    assign prdata    = w_cfg_sel ? PDATA_W'(r_ud_mask) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ud_mask <= MASK_RESET;
        end else if (w_cfg_wr) begin
            r_ud_mask <= pwdata[MASK_W-1:0];
        end
    end

    // Handshake and item decode.
    logic          w_in_acc;
    logic          w_in_range;
    logic          w_turn;
    logic          w_seg_we;
    logic          w_dp_we;
    logic          w_tick;
    logic [IW-1:0] w_addr;
    t_glyph        w_glyph;
    t_glyph        w_seg_wdata;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_in_range = ({1'b0, i_in.digit_index} < (INDEX_W + 1)'(NUM_DIGITS));
    assign w_addr     = i_in.digit_index[IW-1:0];
    assign w_turn     = (i_in.digit_index < 8'd4) && r_ud_mask[i_in.digit_index[1:0]];
    assign w_glyph    = glyph_of(i_in.char_code);
    assign w_seg_wdata = w_turn ? turn_over(w_glyph) : w_glyph;

    always_comb begin
        w_seg_we = 1'b0;
        w_dp_we  = 1'b0;
        w_tick   = 1'b0;
        case (i_in.op)
            OP_WRITE: w_seg_we = w_in_acc && w_in_range;
            OP_POINT: w_dp_we  = w_in_acc && w_in_range;
            OP_TICK:  w_tick   = w_in_acc;
            default:  ;
        endcase
    end

    // Segment and decimal-point memories, written at the accepting edge.
    t_glyph r_seg_mem [NUM_DIGITS];
    logic   r_dp_mem  [NUM_DIGITS];

    always_ff @(posedge i_clk) begin
        if (w_seg_we) begin
            r_seg_mem[w_addr] <= w_seg_wdata;
        end
        if (w_dp_we) begin
            r_dp_mem[w_addr] <= i_in.dp_on;
        end
    end

    // Per-entry valid bits; an entry never written reads as blank.
    logic [NUM_DIGITS-1:0] r_seg_vld;
    logic [NUM_DIGITS-1:0] r_dp_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_vld <= '0;
            r_dp_vld  <= '0;
        end else begin
            if (w_seg_we) begin
                r_seg_vld[w_addr] <= 1'b1;
            end
            if (w_dp_we) begin
                r_dp_vld[w_addr] <= 1'b1;
            end
        end
    end

    // Scan position.
    logic [IW-1:0] r_scan;
    logic [IW-1:0] n_scan;

    assign n_scan = (r_scan == IW'(NUM_DIGITS - 1)) ? '0 : r_scan + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (w_tick) begin
            r_scan <= n_scan;
        end
    end

    // Read stage: registered memory data for the tick transaction in flight.
    t_glyph              r_seg_rd;
    logic                r_dp_rd;
    logic                r_seg_rd_vld;
    logic                r_dp_rd_vld;
    logic [ACTIVE_W-1:0] r_s1_digit;
    logic                r_s1_valid;
    logic [EXTW-1:0]     w_scan_ext;

    assign w_scan_ext = EXTW'(r_scan);

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_seg_rd     <= r_seg_mem[r_scan];
            r_dp_rd      <= r_dp_mem[r_scan];
            r_seg_rd_vld <= r_seg_vld[r_scan];
            r_dp_rd_vld  <= r_dp_vld[r_scan];
            r_s1_digit   <= w_scan_ext[ACTIVE_W-1:0];
        end
    end

    // Output register and stage control.
    logic                r_out_valid;
    logic [SEG_W-1:0]    r_out_seg;
    logic [ACTIVE_W-1:0] r_out_digit;
    logic                w_s1_adv;
    logic [SEG_W-1:0]    w_s1_seg;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_s1_adv;
    assign w_s1_seg   = {r_dp_rd_vld && r_dp_rd, r_seg_rd_vld ? r_seg_rd : GLYPH_BLANK};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_tick) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_seg   <= w_s1_seg;
            r_out_digit <= r_s1_digit;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.segment_bits = r_out_seg;
    assign o_out.active_digit = r_out_digit;

endmodule
